>>> sv/gcb_pkg.sv
package gcb_pkg;

	// arctangent of 2^-i as a binary angle, 2^32 is one full turn
	localparam int unsigned ATAN_N = 32;
	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// 360 degrees in units of 1e-7 degree
	localparam logic signed [34:0] TURN_DEG = 35'sd3600000000;
	// bam = floor(r * 2^22 / BAM_DIV)
	localparam logic [21:0] BAM_DIV = 22'd3515625;
	localparam logic [31:0] BAM_RECIP = 32'((64'd1 << 53) / 64'd3515625);
	// 1/gain in Q30
	localparam logic signed [32:0] INV_GAIN = 33'sd652032874;
	// hundredths of a degree per turn
	localparam logic [15:0] HDG_SCALE = 16'd36000;

	localparam int unsigned SC_W = 32;
	localparam int unsigned PW = 34;

	typedef logic [31:0] bam_t;
	typedef logic signed [SC_W-1:0] trig_t;
	typedef logic signed [PW-1:0] term_t;
	typedef struct packed {
		trig_t s;
		trig_t c;
	} sincos_t;

endpackage

>>> sv/great_circle_bearing_top.sv
// Initial great-circle bearing from a current to a target position. Coordinates
// arrive as signed degrees times 10^7; the heading leaves as hundredths of a degree
// clockwise from north, 0 to 35999, truncated, with identical points and a zero
// vector giving 0. The block is a fully pipelined datapath: one transaction may
// enter every cycle while in_ready is high, and results leave in order of arrival.
// A transaction passes through the degree-to-binary-angle conversion, the
// sine/cosine rotators, the products, the atan2 vectoring pipeline, the final
// scaling and one output register. Each CORDIC iteration is its own pipeline
// stage, which sets the sustained rate of one item per cycle while the output is
// not stalled. A skid register behind the output lets one more transaction in
// while a result waits; in_ready drops only while that skid register is full.
module great_circle_bearing_top import gcb_pkg::*; #(
	parameter int unsigned CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [30:0] here_lat,
	input  logic signed [31:0] here_lon,
	input  logic signed [30:0] goal_lat,
	input  logic signed [31:0] goal_lon,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        heading
);

	// positions of each section along the valid pipe
	localparam int unsigned LAT_BAM = 4;
	localparam int unsigned LAT_ROT = CORDIC_STEPS + 2;
	localparam int unsigned P_IDX = LAT_BAM + LAT_ROT;
	localparam int unsigned LAT_VEC = CORDIC_STEPS + 1;
	localparam int unsigned V_IDX = P_IDX + 3;
	localparam int unsigned H_IDX = V_IDX + LAT_VEC;
	localparam int unsigned DEPTH = H_IDX + 1;

	logic               en;
	logic               push;
	logic [15:0]        push_hdg;
	logic               vld_s [0:DEPTH-1];
	logic               zro_s [0:DEPTH-1];
	logic signed [33:0] lat1;
	logic signed [33:0] lat2;
	logic signed [33:0] dlon;
	bam_t               a1;
	bam_t               a2;
	bam_t               ad;
	logic               ident;
	sincos_t            sc1;
	sincos_t            sc2;
	sincos_t            scd;
	logic signed [63:0] m_num;
	logic signed [63:0] m_t1;
	logic signed [63:0] m_t2;
	logic signed [65:0] m_t3;
	term_t              num_s1;
	term_t              t1_s1;
	term_t              t2_s1;
	trig_t              cd_s1;
	term_t              num_s2;
	term_t              t1_s2;
	term_t              t3_s2;
	term_t              num_s3;
	term_t              den_s3;
	logic               zvec;
	bam_t               ang;
	logic [47:0]        m_hdg;
	logic [15:0]        hdg_s4;
	logic               out_v_q;
	logic [15:0]        hdg_q;
	logic               skid_v_q;
	logic [15:0]        skid_hdg_q;

	// Advance the whole pipe whenever the skid register is free.
	assign en = !skid_v_q;
	assign in_ready = en;

	assign lat1 = 34'(here_lat);
	assign lat2 = 34'(goal_lat);
	assign dlon = 34'(goal_lon) - 34'(here_lon);

	gcb_bam u_bam_lat1 (.clk(clk), .en(en), .deg(lat1), .bam(a1));
	gcb_bam u_bam_lat2 (.clk(clk), .en(en), .deg(lat2), .bam(a2));
	gcb_bam u_bam_dlon (.clk(clk), .en(en), .deg(dlon), .bam(ad));

	// Identical points short-circuit to heading 0.
	assign ident = (a1 == a2) && (ad == '0);

	gcb_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat1 (.clk(clk), .en(en), .ang(a1), .sc(sc1));
	gcb_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat2 (.clk(clk), .en(en), .ang(a2), .sc(sc2));
	gcb_rot #(.STEPS(CORDIC_STEPS)) u_rot_dlon (.clk(clk), .en(en), .ang(ad), .sc(scd));

	// Q30 products; taking bits [63:30] is a floor shift.
	always_comb begin
		m_num = 64'(scd.s) * 64'(sc2.c);
		m_t1 = 64'(sc1.c) * 64'(sc2.s);
		m_t2 = 64'(sc1.s) * 64'(sc2.c);
		m_t3 = 66'(t2_s1) * 66'(cd_s1);
		zvec = (num_s3 == '0) && (den_s3 == '0);
		m_hdg = 48'(ang) * 48'(HDG_SCALE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= m_num[63:30];
			t1_s1 <= m_t1[63:30];
			t2_s1 <= m_t2[63:30];
			cd_s1 <= scd.c;
			num_s2 <= num_s1;
			t1_s2 <= t1_s1;
			t3_s2 <= m_t3[63:30];
			num_s3 <= num_s2;
			den_s3 <= t1_s2 - t3_s2;
			hdg_s4 <= m_hdg[47:32];
		end
	end

	gcb_vec #(.STEPS(CORDIC_STEPS)) u_vec (
		.clk(clk),
		.en(en),
		.num(num_s3),
		.den(den_s3),
		.ang(ang)
	);

	// Valid bits march with the data; the zero flag picks up both special cases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < DEPTH; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zro_s[0] <= 1'b0;
			for (int k = 1; k < DEPTH; k++) begin
				zro_s[k] <= zro_s[k-1] | ((k == LAT_BAM) && ident) | ((k == V_IDX) && zvec);
			end
		end
	end

	assign push = en && vld_s[DEPTH-1];
	assign push_hdg = zro_s[H_IDX] ? 16'd0 : hdg_s4;

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			hdg_q <= skid_v_q ? skid_hdg_q : push_hdg;
		end else if (push) begin
			skid_hdg_q <= push_hdg;
		end
	end

	assign out_valid = out_v_q;
	assign heading = hdg_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (hdg_q < HDG_SCALE))
		else $error("heading out of range");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_ready |=> skid_v_q && $stable(skid_hdg_q))
		else $error("skid register lost its transaction");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_v_q ##1 skid_v_q |-> $past(out_v_q && !out_ready && push))
		else $error("skid register filled without a stalled output");
`endif

endmodule

>>> sv/gcb_bam.sv
module gcb_bam import gcb_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] deg,
	output bam_t               bam
);

	localparam logic signed [34:0] TURN2 = TURN_DEG <<< 1;
	localparam logic [23:0] DIV1 = 24'(BAM_DIV);
	localparam logic [23:0] DIV2 = DIV1 << 1;

	logic signed [34:0] v;
	logic signed [34:0] v_sub;
	logic signed [34:0] v_add;
	logic signed [34:0] v_add2;
	logic [31:0] r;
	logic [31:0] r_s1;
	logic [1:0]  r_lo_s2;
	logic [1:0]  r_lo_s3;
	logic [63:0] prod_s2;
	logic [31:0] q_est;
	logic [53:0] qd_full;
	logic [31:0] q_s3;
	logic [23:0] qd_s3;
	logic [23:0] rem;
	bam_t        bam_s4;

	// reduce into one turn
	always_comb begin
		v = 35'(deg);
		v_sub = v - TURN_DEG;
		v_add = v + TURN_DEG;
		v_add2 = v + TURN2;
		if (v >= TURN_DEG) begin
			r = v_sub[31:0];
		end else if (v >= 0) begin
			r = v[31:0];
		end else if (v_add >= 0) begin
			r = v_add[31:0];
		end else begin
			r = v_add2[31:0];
		end
	end

	// reciprocal estimate is short by at most two; remainder fits 24 bits
	always_comb begin
		q_est = prod_s2[62:31];
		qd_full = 54'(q_est) * 54'(BAM_DIV);
		rem = {r_lo_s3, 22'd0} - qd_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r;
			r_lo_s2 <= r_s1[1:0];
			prod_s2 <= 64'(r_s1) * 64'(BAM_RECIP);
			r_lo_s3 <= r_lo_s2;
			q_s3 <= q_est;
			qd_s3 <= qd_full[23:0];
			if (rem >= DIV2) begin
				bam_s4 <= q_s3 + 32'd2;
			end else if (rem >= DIV1) begin
				bam_s4 <= q_s3 + 32'd1;
			end else begin
				bam_s4 <= q_s3;
			end
		end
	end

	assign bam = bam_s4;

endmodule

>>> sv/gcb_rot.sv
module gcb_rot import gcb_pkg::*; #(
	parameter int unsigned STEPS = 24
) (
	input  logic    clk,
	input  logic    en,
	input  bam_t    ang,
	output sincos_t sc
);

	localparam int unsigned XW = 33;

	logic signed [XW-1:0] x_s [0:STEPS];
	logic signed [XW-1:0] y_s [0:STEPS];
	logic signed [XW-1:0] z_s [0:STEPS];
	logic                 neg_s [0:STEPS];
	logic                 fold;
	bam_t                 a_f;
	logic signed [XW-1:0] x_n;
	logic signed [XW-1:0] y_n;
	sincos_t              sc_s_last;

	// fold the left half-plane onto the right, negate at the end
	always_comb begin
		fold = ang[31] ^ ang[30];
		a_f = fold ? {~ang[31], ang[30:0]} : ang;
		x_n = -x_s[STEPS];
		y_n = -y_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= INV_GAIN;
			y_s[0] <= '0;
			z_s[0] <= XW'($signed(a_f));
			neg_s[0] <= fold;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [XW-1:0] AT = {{(XW-32){1'b0}}, ATAN_TAB[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				if (!z_s[i][XW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s_last.s <= neg_s[STEPS] ? trig_t'(y_n) : trig_t'(y_s[STEPS]);
			sc_s_last.c <= neg_s[STEPS] ? trig_t'(x_n) : trig_t'(x_s[STEPS]);
		end
	end

	assign sc = sc_s_last;

endmodule

>>> sv/gcb_vec.sv
module gcb_vec import gcb_pkg::*; #(
	parameter int unsigned STEPS = 24
) (
	input  logic  clk,
	input  logic  en,
	input  term_t num,
	input  term_t den,
	output bam_t  ang
);

	localparam int unsigned VW = 36;
	localparam bam_t HALF_TURN = 32'h80000000;

	logic signed [VW-1:0] x_s [0:STEPS];
	logic signed [VW-1:0] y_s [0:STEPS];
	bam_t                 z_s [0:STEPS];

	// negative denominator: mirror through the origin, start at half a turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (den[PW-1]) begin
				x_s[0] <= -VW'(den);
				y_s[0] <= -VW'(num);
				z_s[0] <= HALF_TURN;
			end else begin
				x_s[0] <= VW'(den);
				y_s[0] <= VW'(num);
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][VW-1] && (y_s[i] != '0)) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end
			end
		end
	end

	assign ang = z_s[STEPS];

endmodule

>>> test/great_circle_bearing_check.sv
module great_circle_bearing_check #(
	parameter int unsigned CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [30:0] here_lat,
	input  logic signed [31:0] here_lon,
	input  logic signed [30:0] goal_lat,
	input  logic signed [31:0] goal_lon,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [15:0]        heading,
	output int                 fails,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint DEG_TURN = 64'sd3600000000;
	localparam longint DEG_DIV = 64'sd225000000;
	localparam longint INV_GAIN = 64'sd652032874;
	localparam int unsigned N_ROT = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

	logic [15:0] heading_q [$];

	// degrees times 1e7 to binary angle, reduced into one turn
	function automatic logic [31:0] deg_to_bam(longint d);
		longint r;
		r = d % DEG_TURN;
		if (r < 0)
			r += DEG_TURN;
		return 32'((r <<< 28) / DEG_DIV);
	endfunction

	function automatic void rotate(input logic [31:0] a, output longint s, output longint c);
		longint x, y, z, t;
		bit neg;
		x = INV_GAIN;
		y = 0;
		neg = 0;
		if (((a + 32'h40000000) & 32'h80000000) != 0) begin
			a ^= 32'h80000000;
			neg = 1;
		end
		z = longint'($signed(a));
		for (int i = 0; i < N_ROT; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(gcb_pkg::ATAN_TAB[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(gcb_pkg::ATAN_TAB[i]);
			end
			x = t;
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endfunction

	function automatic logic [31:0] vector_angle(longint y, longint x);
		logic [31:0] z;
		longint t;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		for (int i = 0; i < N_ROT; i++) begin
			if (y > 0) begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += gcb_pkg::ATAN_TAB[i];
			end else begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= gcb_pkg::ATAN_TAB[i];
			end
			x = t;
		end
		return z;
	endfunction

	function automatic logic [15:0] predict_heading(longint lat1, longint lon1,
			longint lat2, longint lon2);
		logic [31:0] a1, a2, ad, ang;
		longint s1, c1, s2, c2, sd, cd, num, den;
		logic [63:0] wide;
		a1 = deg_to_bam(lat1);
		a2 = deg_to_bam(lat2);
		ad = deg_to_bam(lon2 - lon1);
		if (a1 == a2 && ad == 0)
			return 16'd0;
		rotate(a1, s1, c1);
		rotate(a2, s2, c2);
		rotate(ad, sd, cd);
		num = (sd * c2) >>> 30;
		den = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
		if (num == 0 && den == 0)
			return 16'd0;
		ang = vector_angle(num, den);
		wide = (64'(ang) * 64'd36000) >> 32;
		return wide[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			fails <= 0;
			pending <= 0;
			heading_q.delete();
		end else begin
			if (in_valid && in_ready)
				heading_q.push_back(predict_heading(here_lat, here_lon, goal_lat, goal_lon));
			if (out_valid && out_ready) begin
				if (heading_q.size() == 0) begin
					$display("%0t: unexpected heading %0d", $time, heading);
					fails <= fails + 1;
				end else begin
					want = heading_q.pop_front();
					if (want !== heading) begin
						$display("%0t: heading expected %0d actual %0d", $time, want, heading);
						fails <= fails + 1;
					end
				end
			end
			pending <= heading_q.size();
		end
	end

endmodule

>>> test/great_circle_bearing_top_test.sv
module great_circle_bearing_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1130;
	// cycles with no transaction on either side before giving up
	localparam int STALL_LIMIT = 4000;
	// long receiver hold-off, well beyond the pipeline depth
	localparam int HOLD_CYCLES = 300;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [30:0] here_lat = '0;
	logic signed [31:0] here_lon = '0;
	logic signed [30:0] goal_lat = '0;
	logic signed [31:0] goal_lon = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [15:0]        heading;
	int                 fails;
	int                 pending;
	bit                 burst_in = 0;
	bit                 burst_out = 0;
	int                 idle_cycles = 0;

	always #2 clk = ~clk;

	great_circle_bearing_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.here_lat(here_lat), .here_lon(here_lon),
		.goal_lat(goal_lat), .goal_lon(goal_lon),
		.out_valid(out_valid), .out_ready(out_ready), .heading(heading)
	);

	great_circle_bearing_check check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.here_lat(here_lat), .here_lon(here_lon),
		.goal_lat(goal_lat), .goal_lon(goal_lon),
		.out_valid(out_valid), .out_ready(out_ready), .heading(heading),
		.fails(fails), .pending(pending)
	);

	// Offer one position pair after a random gap; return at the edge that accepts it.
	// Keep valid high across back-to-back transactions so it is never dropped and
	// raised at the same edge.
	task automatic offer(input logic signed [30:0] lat1, input logic signed [31:0] lon1,
			input logic signed [30:0] lat2, input logic signed [31:0] lon2);
		int gap;
		gap = burst_in ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		here_lat <= lat1;
		here_lon <= lon1;
		goal_lat <= lat2;
		goal_lon <= lon2;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic signed [31:0] pick_lon();
		case ($urandom_range(0, 3))
			0: return $signed($urandom);
			1: return $signed($urandom_range(0, 3600000000)) - 32'sd1800000000;
			2: return (32'sd1800000000 - $signed($urandom_range(0, 1000)));
			default: return $signed($urandom_range(0, 2000)) - 32'sd1000;
		endcase
	endfunction

	function automatic logic signed [30:0] pick_lat();
		case ($urandom_range(0, 3))
			0: return 31'($urandom);
			1, 2: return 31'($signed($urandom_range(0, 1800000000)) - 32'sd900000000);
			default: return 31'(32'sd900000000 - $signed($urandom_range(0, 1000)));
		endcase
	endfunction

	// Stimulus: directed corners, then random pairs in phases of changing pace.
	initial begin
		logic signed [30:0] la1, la2;
		logic signed [31:0] lo1, lo2;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identical points, including with longitudes a full turn apart
		offer(31'sd0, 32'sd0, 31'sd0, 32'sd0);
		offer(31'sd123456789, 32'sd987654321, 31'sd123456789, 32'sd987654321);
		offer(31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000);
		// due north, south, east, west
		offer(31'sd0, 32'sd0, 31'sd100000000, 32'sd0);
		offer(31'sd0, 32'sd0, -31'sd100000000, 32'sd0);
		offer(31'sd0, 32'sd0, 31'sd0, 32'sd100000000);
		offer(31'sd0, 32'sd0, 31'sd0, -32'sd100000000);
		// poles and antipodes, where numerator and denominator may both vanish
		offer(31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0);
		offer(-31'sd900000000, 32'sd0, 31'sd900000000, 32'sd1800000000);
		offer(31'sd0, 32'sd0, 31'sd0, 32'sd1800000000);
		offer(31'sd900000000, 32'sd450000000, 31'sd900000000, -32'sd450000000);
		// tiny north-westward step, heading in the north-west quadrant
		offer(31'sd0, 32'sd0, 31'sd1, -32'sd1);
		offer(31'sd10, 32'sd0, 31'sd11, -32'sd1);
		// raw field extremes, out of geographic range
		offer(-31'sd1073741824, -32'sd2147483648, 31'sd1073741823, 32'sd2147483647);
		offer(31'sd1073741823, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648);
		offer(-31'sd1073741824, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648);
		offer(31'sd1073741823, 32'sd0, 31'sd0, 32'sd0);
		offer(-31'sd1, -32'sd1, 31'sd0, 32'sd0);
		offer(-31'sd900000000, -32'sd1800000000, 31'sd900000000, 32'sd1800000000);

		// pause until the pipeline drains; let the last count settle first
		in_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 150 == 0) begin
				burst_in = $urandom_range(0, 2) == 0;
				burst_out = $urandom_range(0, 2) == 0;
			end
			if (n == 600) begin
				in_valid <= 0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			la1 = pick_lat();
			lo1 = pick_lon();
			case ($urandom_range(0, 9))
				0: begin
					la2 = la1;
					lo2 = lo1;
				end
				1, 2: begin
					la2 = la1 + 31'($signed($urandom_range(0, 2000)) - 1000);
					lo2 = lo1 + ($signed($urandom_range(0, 2000)) - 1000);
				end
				default: begin
					la2 = pick_lat();
					lo2 = pick_lon();
				end
			endcase
			offer(la1, lo1, la2, lo2);
		end
		in_valid <= 0;

		// drain, then allow the pipeline depth once more
		@(posedge clk);
		wait (pending == 0);
		repeat (80) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: random stalls per result; hold off once for a long stretch so the
	// pipeline fills and in_ready drops.
	initial begin
		int stall;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 200)
				stall = HOLD_CYCLES;
			else
				stall = burst_out ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
